/* rtl/core/gpioei_pkg.sv */
`timescale 1ns / 1ps

package gpioei_pkg;

  localparam int unsigned PIN_COUNT = 32;
  localparam int unsigned WordW     = 32;

  // pins above PIN_COUNT never hold an enable or a status bit
  localparam logic [WordW-1:0] PinMask = {WordW{1'b1}} >> (WordW - PIN_COUNT);

  typedef enum logic [1:0] {
    OpSample = 2'd0,
    OpRead   = 2'd1,
    OpWrite  = 2'd2,
    OpNone   = 2'd3
  } op_e;

  typedef enum logic [3:0] {
    RegSummary = 4'd0,
    RegRise0   = 4'd1,
    RegFall0   = 4'd2,
    RegClear0  = 4'd3,
    RegRiseEn0 = 4'd4,
    RegFallEn0 = 4'd5,
    RegRise2   = 4'd6,
    RegFall2   = 4'd7,
    RegClear2  = 4'd8,
    RegRiseEn2 = 4'd9,
    RegFallEn2 = 4'd10
  } reg_e;

  typedef struct packed {
    logic sample;     // compare with stored levels
    logic prime;      // only store levels
    logic wr_rise_en;
    logic wr_fall_en;
    logic clear;
  } port_ctrl_t;

  typedef struct packed {
    logic [WordW-1:0] rise_status;
    logic [WordW-1:0] fall_status;
    logic [WordW-1:0] rise_enable;
    logic [WordW-1:0] fall_enable;
    logic             pending_next;
  } port_stat_t;

endpackage

/* rtl/core/gpioei_port.sv */
`timescale 1ns / 1ps

module gpioei_port (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  gpioei_pkg::port_ctrl_t          ctrl_i,
  input  logic [gpioei_pkg::WordW-1:0]    levels_i,
  input  logic [gpioei_pkg::WordW-1:0]    wdata_i,
  output gpioei_pkg::port_stat_t          stat_o
);
  import gpioei_pkg::*;

  logic [WordW-1:0] last_q, last_d;
  logic [WordW-1:0] rise_en_q, rise_en_d;
  logic [WordW-1:0] fall_en_q, fall_en_d;
  logic [WordW-1:0] rise_st_q, rise_st_d;
  logic [WordW-1:0] fall_st_q, fall_st_d;
  logic [WordW-1:0] lv;
  logic [WordW-1:0] wv;

  assign lv = levels_i & PinMask;
  assign wv = wdata_i & PinMask;

  always_comb begin
    last_d    = last_q;
    rise_en_d = rise_en_q;
    fall_en_d = fall_en_q;
    rise_st_d = rise_st_q;
    fall_st_d = fall_st_q;
    if (ctrl_i.sample) begin
      rise_st_d = rise_st_q | (~last_q & lv & rise_en_q);
      fall_st_d = fall_st_q | (last_q & ~lv & fall_en_q);
    end
    if (ctrl_i.sample || ctrl_i.prime) begin
      last_d = lv;
    end
    if (ctrl_i.clear) begin
      rise_st_d = rise_st_q & ~wv;
      fall_st_d = fall_st_q & ~wv;
    end
    if (ctrl_i.wr_rise_en) begin
      rise_en_d = wv;
    end
    if (ctrl_i.wr_fall_en) begin
      fall_en_d = wv;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_q    <= '0;
      rise_en_q <= '0;
      fall_en_q <= '0;
      rise_st_q <= '0;
      fall_st_q <= '0;
    end else begin
      last_q    <= last_d;
      rise_en_q <= rise_en_d;
      fall_en_q <= fall_en_d;
      rise_st_q <= rise_st_d;
      fall_st_q <= fall_st_d;
    end
  end

  assign stat_o.rise_status  = rise_st_q;
  assign stat_o.fall_status  = fall_st_q;
  assign stat_o.rise_enable  = rise_en_q;
  assign stat_o.fall_enable  = fall_en_q;
  assign stat_o.pending_next = |(rise_st_d | fall_st_d);

  // a rising status bit only appears on a sample through an enabled pin
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !ctrl_i.sample |=> ((rise_st_q & ~$past(rise_st_q)) == '0))
    else $error("rise status set outside a sample");

  // pins above the configured count stay clear
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((rise_st_q | fall_st_q | rise_en_q | fall_en_q) & ~PinMask) == '0)
    else $error("unused pin bit set");

endmodule

/* rtl/core/gpio_edge_interrupt_controller.sv */
`timescale 1ns / 1ps

// a word is held in the input register, then its result in the result register
// one word per cycle while out_ready_i is not held low: input register -> decode/update -> result register
// while a result waits the input register takes one more word, then the input stalls
// reset clears levels, enables, status, the primed flag and both valid flags
// the first sample after reset only stores the pin levels
module gpio_edge_interrupt_controller (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [1:0]                   operation_i,
  input  logic [3:0]                   register_select_i,
  input  logic [gpioei_pkg::WordW-1:0] write_value_i,
  input  logic [gpioei_pkg::WordW-1:0] port0_levels_i,
  input  logic [gpioei_pkg::WordW-1:0] port2_levels_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [gpioei_pkg::WordW-1:0] read_data_o,
  output logic                         interrupt_request_o,
  output logic                         port0_pending_o,
  output logic                         port2_pending_o
);
  import gpioei_pkg::*;

  // input register
  logic             in_valid_q, in_valid_d;
  op_e              op_q;
  logic [3:0]       sel_q;
  logic [WordW-1:0] wv_q;
  logic [WordW-1:0] p0_q;
  logic [WordW-1:0] p2_q;

  // result register
  logic             out_valid_q, out_valid_d;
  logic [WordW-1:0] rdata_q, rdata_d;
  logic             pend0_q, pend2_q;

  logic       primed_q, primed_d;
  logic       move;
  logic       in_fire;
  port_ctrl_t ctrl0, ctrl2;
  port_stat_t stat0, stat2;

  assign move       = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || move;
  assign in_fire    = in_valid_i && in_ready_o;

  assign in_valid_d  = in_fire || (in_valid_q && !move);
  assign out_valid_d = move || (out_valid_q && !out_ready_i);

  always_comb begin
    ctrl0    = '0;
    ctrl2    = '0;
    primed_d = primed_q;
    if (move) begin
      case (op_q)
        OpSample: begin
          ctrl0.sample = primed_q;
          ctrl2.sample = primed_q;
          ctrl0.prime  = !primed_q;
          ctrl2.prime  = !primed_q;
          primed_d     = 1'b1;
        end
        OpWrite: begin
          case (sel_q)
            RegClear0:  ctrl0.clear      = 1'b1;
            RegRiseEn0: ctrl0.wr_rise_en = 1'b1;
            RegFallEn0: ctrl0.wr_fall_en = 1'b1;
            RegClear2:  ctrl2.clear      = 1'b1;
            RegRiseEn2: ctrl2.wr_rise_en = 1'b1;
            RegFallEn2: ctrl2.wr_fall_en = 1'b1;
            default: ;
          endcase
        end
        default: ;
      endcase
    end
  end

  gpioei_port u_port0 (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctrl_i  (ctrl0),
    .levels_i(p0_q),
    .wdata_i (wv_q),
    .stat_o  (stat0)
  );

  gpioei_port u_port2 (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctrl_i  (ctrl2),
    .levels_i(p2_q),
    .wdata_i (wv_q),
    .stat_o  (stat2)
  );

  // a read leaves the state alone, so current registers give the read value
  always_comb begin
    rdata_d = '0;
    if (op_q == OpRead) begin
      case (sel_q)
        RegSummary: rdata_d = {{(WordW-2){1'b0}}, stat2.pending_next, stat0.pending_next};
        RegRise0:   rdata_d = stat0.rise_status;
        RegFall0:   rdata_d = stat0.fall_status;
        RegRiseEn0: rdata_d = stat0.rise_enable;
        RegFallEn0: rdata_d = stat0.fall_enable;
        RegRise2:   rdata_d = stat2.rise_status;
        RegFall2:   rdata_d = stat2.fall_status;
        RegRiseEn2: rdata_d = stat2.rise_enable;
        RegFallEn2: rdata_d = stat2.fall_enable;
        default:    rdata_d = '0;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      primed_q    <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
      primed_q    <= primed_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      op_q  <= op_e'(operation_i);
      sel_q <= register_select_i;
      wv_q  <= write_value_i;
      p0_q  <= port0_levels_i;
      p2_q  <= port2_levels_i;
    end
    if (move) begin
      rdata_q <= rdata_d;
      pend0_q <= stat0.pending_next;
      pend2_q <= stat2.pending_next;
    end
  end

  assign out_valid_o         = out_valid_q;
  assign read_data_o         = rdata_q;
  assign interrupt_request_o = pend0_q | pend2_q;
  assign port0_pending_o     = pend0_q;
  assign port2_pending_o     = pend2_q;

  // input side only stalls when both registers hold a word
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (in_valid_q && out_valid_q && !out_ready_i))
    else $error("input stalled without a full pipeline");

  // only reads produce non-zero read data
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (move && op_q != OpRead) |=> (read_data_o == '0))
    else $error("read data non-zero outside a read");

  // any sample leaves the level store primed
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (move && op_q == OpSample) |=> primed_q)
    else $error("sample did not prime level store");

  // summary read matches the pending flags returned with it
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (move && op_q == OpRead && sel_q == RegSummary) |=>
      (read_data_o[1:0] == {port2_pending_o, port0_pending_o}))
    else $error("summary read disagrees with pending flags");

endmodule
